/* rtl/core/encoder_speed_estimator_macros.svh */
// assertion macros for the encoder speed estimator
// expects clk and rst_n in the scope of the module that uses them
`ifndef ENCODER_SPEED_ESTIMATOR_MACROS_SVH
`define ENCODER_SPEED_ESTIMATOR_MACROS_SVH
`ifndef ASSERT_OFF
// property checked on every clock edge outside reset
`define ESE_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("encoder speed estimator check failed");
// condition in one cycle implies a condition in the next
`define ESE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("encoder speed estimator check failed");
`else
`define ESE_ASSERT(lbl, prop)
`define ESE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* rtl/core/ese_pkg.sv */
// shared widths, register map and reset values of the encoder speed estimator
// no dependencies
`timescale 1ns / 1ps

package ese_pkg;

    // field widths
    localparam int COUNT_W = 16;
    localparam int TIME_W  = 32;
    localparam int SPEED_W = 32;
    localparam int SCALE_W = 16;

    // apb port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // register indexes, address bits [3:2]
    localparam logic [1:0] REG_COUNTS_PER_REV = 2'd0;
    localparam logic [1:0] REG_RPM_SCALE      = 2'd1;
    localparam logic [1:0] REG_VEL_SCALE      = 2'd2;

    // register reset values
    localparam logic [SCALE_W-1:0] RST_COUNTS_PER_REV = 16'd1560;
    localparam logic [SCALE_W-1:0] RST_RPM_SCALE      = 16'd9846;
    localparam logic [SCALE_W-1:0] RST_VEL_SCALE      = 16'd34542;

endpackage

/* rtl/core/ese_if.sv */
// valid/ready channels for samples in and speed words out
// depends on ese_pkg
`timescale 1ns / 1ps

interface ese_sample_if;
    import ese_pkg::*;

    logic               valid;
    logic               ready;
    logic               channel;
    logic [COUNT_W-1:0] counter_value;
    logic [TIME_W-1:0]  time_ms;

    modport source (output valid, channel, counter_value, time_ms, input ready);
    modport sink   (input valid, channel, counter_value, time_ms, output ready);
endinterface

interface ese_result_if;
    import ese_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      channel_echo;
    logic                      updated;
    logic                      direction;
    logic signed [SPEED_W-1:0] rpm_q8;
    logic signed [SPEED_W-1:0] velocity_q8;
    logic [COUNT_W-1:0]        revolutions;

    modport source (output valid, channel_echo, updated, direction, rpm_q8, velocity_q8,
                    revolutions, input ready);
    modport sink   (input valid, channel_echo, updated, direction, rpm_q8, velocity_q8,
                    revolutions, output ready);
endinterface

/* rtl/core/encoder_speed_estimator.sv */
// Flow: an accepted sample passes S_DELTA and the revolution division; when speeds are
// recomputed it then passes an rpm and a velocity multiply and divide, and the word waits
// in S_FINISH until the output slot is free. A new sample is accepted only in S_IDLE, once
// the previous word is loaded; the shared one-bit-per-cycle divider runs the revolution,
// rpm and velocity divisions one after another.
// Reset: registers return to their default values, per-channel history and speeds clear.
`timescale 1ns / 1ps
`include "encoder_speed_estimator_macros.svh"

module encoder_speed_estimator #(
    parameter int CHANNELS = 2
) (
    input  logic                            clk,
    input  logic                            rst_n,
    ese_sample_if.sink                      sample,
    ese_result_if.source                    result,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ese_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [ese_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [ese_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import ese_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DELTA,
        S_DIV,
        S_MUL,
        S_FINISH
    } state_t;

    typedef enum logic [1:0] {
        PH_REV,
        PH_RPM,
        PH_VEL
    } phase_t;

    // configuration registers
    logic [SCALE_W-1:0] counts_per_rev_reg;
    logic [SCALE_W-1:0] rpm_scale_reg;
    logic [SCALE_W-1:0] vel_scale_reg;

    // per-channel history and held speeds
    logic [COUNT_W-1:0]        prev_count_reg [CHANNELS];
    logic [TIME_W-1:0]         prev_time_reg  [CHANNELS];
    logic                      held_dir_reg   [CHANNELS];
    logic signed [SPEED_W-1:0] held_rpm_reg   [CHANNELS];
    logic signed [SPEED_W-1:0] held_vel_reg   [CHANNELS];

    // sequencer and captured sample
    state_t             state_reg;
    phase_t             phase_reg;
    logic [4:0]         step_reg;
    logic               channel_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [TIME_W-1:0]  time_reg;
    logic               neg_reg;
    logic [COUNT_W-1:0] mag_reg;
    logic [TIME_W-1:0]  dt_reg;
    logic               upd_reg;
    logic [COUNT_W-1:0] revs_reg;

    // shared divider
    logic [31:0] rem_reg;
    logic [31:0] quo_reg;
    logic [31:0] div_reg;

    // output word register
    logic                      out_valid_reg;
    logic                      out_channel_reg;
    logic                      out_updated_reg;
    logic                      out_dir_reg;
    logic signed [SPEED_W-1:0] out_rpm_reg;
    logic signed [SPEED_W-1:0] out_vel_reg;
    logic [COUNT_W-1:0]        out_revs_reg;

    logic               wr_en;
    logic [CH_W-1:0]    idx;
    logic               ch_valid;
    logic [COUNT_W-1:0] diff;
    logic [TIME_W-1:0]  dt;
    logic [32:0]        r_shift;
    logic               take;
    logic [31:0]        rem_step;
    logic [31:0]        quo_step;
    logic [31:0]        signed_q;
    logic [SCALE_W-1:0] scale_sel;
    logic [31:0]        product;
    logic               out_free;

    // apb access, always ready
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_COUNTS_PER_REV: prdata = {16'd0, counts_per_rev_reg};
            REG_RPM_SCALE:      prdata = {16'd0, rpm_scale_reg};
            REG_VEL_SCALE:      prdata = {16'd0, vel_scale_reg};
            default:            prdata = '0;
        endcase
    end

    // channel lookup
    assign idx      = CH_W'(channel_reg);
    assign ch_valid = int'(channel_reg) < CHANNELS;

    // count and time differences, both wrap
    assign diff = count_reg - prev_count_reg[idx];
    assign dt   = time_reg - prev_time_reg[idx];

    // one restoring divider step
    assign r_shift  = {rem_reg, quo_reg[31]};
    assign take     = r_shift >= {1'b0, div_reg};
    assign rem_step = take ? 32'(r_shift - {1'b0, div_reg}) : r_shift[31:0];
    assign quo_step = {quo_reg[30:0], take};
    // magnitude stays below 2^31, so negation never saturates
    assign signed_q = neg_reg ? (32'd0 - quo_step) : quo_step;

    // scale times count magnitude
    assign scale_sel = (phase_reg == PH_RPM) ? rpm_scale_reg : vel_scale_reg;
    assign product   = 32'(mag_reg) * 32'(scale_sel);

    assign out_free     = !out_valid_reg || result.ready;
    assign sample.ready = (state_reg == S_IDLE);

    assign result.valid        = out_valid_reg;
    assign result.channel_echo = out_channel_reg;
    assign result.updated      = out_updated_reg;
    assign result.direction    = out_dir_reg;
    assign result.rpm_q8       = out_rpm_reg;
    assign result.velocity_q8  = out_vel_reg;
    assign result.revolutions  = out_revs_reg;

    // configuration, sequencer, state and output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counts_per_rev_reg <= RST_COUNTS_PER_REV;
            rpm_scale_reg      <= RST_RPM_SCALE;
            vel_scale_reg      <= RST_VEL_SCALE;
            for (int i = 0; i < CHANNELS; i++)
            begin
                prev_count_reg[i] <= '0;
                prev_time_reg[i]  <= '0;
                held_dir_reg[i]   <= 1'b0;
                held_rpm_reg[i]   <= '0;
                held_vel_reg[i]   <= '0;
            end
            state_reg     <= S_IDLE;
            phase_reg     <= PH_REV;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                unique case (paddr[3:2])
                    REG_COUNTS_PER_REV: counts_per_rev_reg <= pwdata[SCALE_W-1:0];
                    REG_RPM_SCALE:      rpm_scale_reg      <= pwdata[SCALE_W-1:0];
                    REG_VEL_SCALE:      vel_scale_reg      <= pwdata[SCALE_W-1:0];
                    default:            ;
                endcase
            end

            // word taken and no new word loaded in the same cycle
            if (result.valid && result.ready && (state_reg != S_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (sample.valid)
                    begin
                        channel_reg <= sample.channel;
                        count_reg   <= sample.counter_value;
                        time_reg    <= sample.time_ms;
                        state_reg   <= S_DELTA;
                    end
                end
                S_DELTA:
                begin
                    neg_reg   <= diff[COUNT_W-1];
                    mag_reg   <= diff[COUNT_W-1] ? COUNT_W'(~diff + 16'd1) : diff;
                    dt_reg    <= dt;
                    upd_reg   <= ch_valid && (dt != '0);
                    // revolution count first, 16 quotient bits
                    rem_reg   <= '0;
                    quo_reg   <= {count_reg, 16'd0};
                    div_reg   <= {16'd0, counts_per_rev_reg};
                    step_reg  <= 5'd15;
                    phase_reg <= PH_REV;
                    state_reg <= S_DIV;
                end
                S_MUL:
                begin
                    rem_reg   <= '0;
                    quo_reg   <= product;
                    div_reg   <= dt_reg;
                    step_reg  <= 5'd31;
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    rem_reg  <= rem_step;
                    quo_reg  <= quo_step;
                    step_reg <= step_reg - 5'd1;
                    if (step_reg == '0)
                    begin
                        unique case (phase_reg)
                            PH_REV:
                            begin
                                revs_reg  <= quo_step[COUNT_W-1:0];
                                phase_reg <= PH_RPM;
                                state_reg <= upd_reg ? S_MUL : S_FINISH;
                            end
                            PH_RPM:
                            begin
                                held_rpm_reg[idx] <= signed_q;
                                phase_reg         <= PH_VEL;
                                state_reg         <= S_MUL;
                            end
                            PH_VEL:
                            begin
                                held_vel_reg[idx]   <= signed_q;
                                held_dir_reg[idx]   <= neg_reg;
                                prev_count_reg[idx] <= count_reg;
                                prev_time_reg[idx]  <= time_reg;
                                state_reg           <= S_FINISH;
                            end
                            default:
                            begin
                                state_reg <= S_FINISH;
                            end
                        endcase
                    end
                end
                S_FINISH:
                begin
                    // wait until the output slot is free
                    if (out_free)
                    begin
                        out_valid_reg   <= 1'b1;
                        out_channel_reg <= channel_reg;
                        out_updated_reg <= upd_reg;
                        out_dir_reg     <= ch_valid ? held_dir_reg[idx] : 1'b0;
                        out_rpm_reg     <= ch_valid ? held_rpm_reg[idx] : '0;
                        out_vel_reg     <= ch_valid ? held_vel_reg[idx] : '0;
                        out_revs_reg    <= revs_reg;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // checks
    `ESE_ASSERT_NEXT(a_accept_starts, sample.valid && sample.ready, state_reg == S_DELTA)
    `ESE_ASSERT(a_rem_below_div, (state_reg == S_DIV && div_reg != '0) |-> (rem_reg < div_reg))
    `ESE_ASSERT(a_mul_only_updating, (state_reg == S_MUL) |-> (upd_reg && ch_valid))
    `ESE_ASSERT_NEXT(a_finish_waits, state_reg == S_FINISH && result.valid && !result.ready,
                     state_reg == S_FINISH)

endmodule

/* verif/encoder_speed_estimator_tb.sv */
// self-checking testbench for encoder_speed_estimator: samples in, speed words out, apb setup
// depends on ese_pkg, ese_sample_if, ese_result_if and the encoder_speed_estimator rtl
`timescale 1ns / 1ps

module encoder_speed_estimator_tb;
    import ese_pkg::*;

    localparam int CHANNELS      = 2;
    localparam int SETTLE_CYCLES = 100;
    localparam int STALL_LIMIT   = 20000;
    localparam int MAX_REPORTS   = 30;
    localparam int RANDOM_ITEMS  = 200;

    // register slot past the end of the map, writes there must be ignored
    localparam logic [1:0] REG_UNUSED = 2'd3;

    localparam longint SPEED_MAX = 64'sd2147483647;
    localparam longint SPEED_MIN = -64'sd2147483648;

    // one result word as the block reports it
    typedef struct packed {
        logic                      channel_echo;
        logic                      updated;
        logic                      direction;
        logic signed [SPEED_W-1:0] rpm_q8;
        logic signed [SPEED_W-1:0] velocity_q8;
        logic [COUNT_W-1:0]        revolutions;
    } speed_word_t;

    // speed predictor with its own copy of registers and per-channel history
    class speed_scoreboard;
        logic [SCALE_W-1:0]        counts_per_rev;
        logic [SCALE_W-1:0]        rpm_scale;
        logic [SCALE_W-1:0]        vel_scale;
        logic [COUNT_W-1:0]        seen_count [CHANNELS];
        logic [TIME_W-1:0]         last_time  [CHANNELS];
        logic                      held_dir   [CHANNELS];
        logic signed [SPEED_W-1:0] held_rpm   [CHANNELS];
        logic signed [SPEED_W-1:0] held_vel   [CHANNELS];
        speed_word_t               expected_words [$];
        int                        errors;
        int                        checked;
        int                        updates;
        int                        holds;
        int                        reports;

        function new();
            counts_per_rev = RST_COUNTS_PER_REV;
            rpm_scale      = RST_RPM_SCALE;
            vel_scale      = RST_VEL_SCALE;
            for (int i = 0; i < CHANNELS; i++)
            begin
                seen_count[i] = '0;
                last_time[i]  = '0;
                held_dir[i]   = 1'b0;
                held_rpm[i]   = '0;
                held_vel[i]   = '0;
            end
            errors  = 0;
            checked = 0;
            updates = 0;
            holds   = 0;
            reports = 0;
        endfunction

        // register write seen on the apb port, only the low half is kept
        function void write_reg(logic [1:0] idx, logic [APB_DATA_W-1:0] data);
            case (idx)
                REG_COUNTS_PER_REV: counts_per_rev = data[SCALE_W-1:0];
                REG_RPM_SCALE:      rpm_scale      = data[SCALE_W-1:0];
                REG_VEL_SCALE:      vel_scale      = data[SCALE_W-1:0];
                default:            ;
            endcase
        endfunction

        // delta * scale / dt, truncated toward zero, clamped to 32 bits signed
        function logic signed [SPEED_W-1:0] scaled_rate(int delta, logic [SCALE_W-1:0] scale,
                                                        logic [TIME_W-1:0] dt);
            longint num;
            longint quo;
            num = longint'(delta) * longint'({48'd0, scale});
            quo = num / longint'({32'd0, dt});
            if (quo > SPEED_MAX)
                return SPEED_MAX[SPEED_W-1:0];
            if (quo < SPEED_MIN)
                return SPEED_MIN[SPEED_W-1:0];
            return quo[SPEED_W-1:0];
        endfunction

        // accepted sample: advance the channel history and queue its speed word
        function void note_sample(logic ch, logic [COUNT_W-1:0] cnt, logic [TIME_W-1:0] ts);
            speed_word_t       w;
            logic [COUNT_W-1:0] diff;
            logic [TIME_W-1:0]  dt;
            int                 delta;
            w.channel_echo = ch;
            w.revolutions  = (counts_per_rev == '0) ? '1 : cnt / counts_per_rev;
            diff  = cnt - seen_count[ch];
            delta = $signed(diff);
            dt    = ts - last_time[ch];
            w.updated = (dt != '0);
            if (w.updated)
            begin
                held_dir[ch]   = (delta < 0);
                held_rpm[ch]   = scaled_rate(delta, rpm_scale, dt);
                held_vel[ch]   = scaled_rate(delta, vel_scale, dt);
                seen_count[ch] = cnt;
                last_time[ch]  = ts;
                updates++;
            end
            else
            begin
                holds++;
            end
            w.direction   = held_dir[ch];
            w.rpm_q8      = held_rpm[ch];
            w.velocity_q8 = held_vel[ch];
            expected_words.push_back(w);
        endfunction

        function void mismatch(string field, longint exp_v, longint got_v);
            errors++;
            if (reports < MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, got_v);
            reports++;
        endfunction

        // accepted result word: compare against the oldest pending one
        function void check_word(speed_word_t got);
            speed_word_t w;
            if (expected_words.size() == 0)
            begin
                errors++;
                $display("%0t: result word with nothing pending, expected none, actual ch %0d",
                         $time, got.channel_echo);
                return;
            end
            w = expected_words.pop_front();
            checked++;
            if (got.channel_echo !== w.channel_echo)
                mismatch("channel_echo", w.channel_echo, got.channel_echo);
            if (got.updated !== w.updated)
                mismatch("updated", w.updated, got.updated);
            if (got.direction !== w.direction)
                mismatch("direction", w.direction, got.direction);
            if (got.rpm_q8 !== w.rpm_q8)
                mismatch("rpm_q8", w.rpm_q8, got.rpm_q8);
            if (got.velocity_q8 !== w.velocity_q8)
                mismatch("velocity_q8", w.velocity_q8, got.velocity_q8);
            if (got.revolutions !== w.revolutions)
                mismatch("revolutions", w.revolutions, got.revolutions);
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    ese_sample_if sample_ch ();
    ese_result_if result_ch ();

    speed_scoreboard sb = new();

    int                 stall_pct = 0;
    int                 settings_used = 1;
    int                 idle_cycles = 0;
    logic [COUNT_W-1:0] sent_count [CHANNELS];
    logic [TIME_W-1:0]  sent_time  [CHANNELS];

    encoder_speed_estimator #(
        .CHANNELS (CHANNELS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .sample  (sample_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 clk = ~clk;

    // monitor: feed accepted samples, words and register writes to the scoreboard
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sample_ch.valid && sample_ch.ready)
                sb.note_sample(sample_ch.channel, sample_ch.counter_value, sample_ch.time_ms);
            if (result_ch.valid && result_ch.ready)
                sb.check_word('{result_ch.channel_echo, result_ch.updated, result_ch.direction,
                                result_ch.rpm_q8, result_ch.velocity_q8, result_ch.revolutions});
            if (psel && penable && pwrite && pready)
                sb.write_reg(paddr[APB_ADDR_W-1:2], pwdata);
        end
    end

    // watchdog on cycles with no handshake of any kind
    always @(posedge clk)
    begin
        if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
            || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles, %0d words pending",
                     $time, idle_cycles, sb.pending());
            $display("Verification failed");
            $finish;
        end
    end

    // receiver: ready drops at random according to the current stall rate
    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            result_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // send one sample word, called and returning at a falling edge
    task automatic push_sample(input logic ch, input logic [COUNT_W-1:0] cnt,
                               input logic [TIME_W-1:0] ts, input int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(negedge clk);
        end
        sample_ch.valid         <= 1'b1;
        sample_ch.channel       <= ch;
        sample_ch.counter_value <= cnt;
        sample_ch.time_ms       <= ts;
        sent_count[ch] = cnt;
        sent_time[ch]  = ts;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // wait until every word has come back and the block has gone quiet
    task automatic drain();
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // apb write: setup then access, upper data bits carry junk
    task automatic apb_write(input logic [1:0] idx, input logic [SCALE_W-1:0] value);
        logic [APB_DATA_W-SCALE_W-1:0] junk;
        junk = (APB_DATA_W-SCALE_W)'($urandom);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {junk, value};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    task automatic configure(input logic [SCALE_W-1:0] cpr, input logic [SCALE_W-1:0] rpm,
                             input logic [SCALE_W-1:0] vel);
        drain();
        apb_write(REG_COUNTS_PER_REV, cpr);
        apb_write(REG_RPM_SCALE, rpm);
        apb_write(REG_VEL_SCALE, vel);
        settings_used++;
    endtask

    // random samples: mostly plausible motion per channel, the rest raw noise
    task automatic random_samples(input int count, input int idle_pct);
        logic               ch;
        logic [COUNT_W-1:0] cnt;
        logic [TIME_W-1:0]  ts;
        int                 pick;
        for (int i = 0; i < count; i++)
        begin
            ch   = 1'($urandom_range(1));
            pick = $urandom_range(99);
            if (pick < 80)
            begin
                case ($urandom_range(19))
                    0:       ts = sent_time[ch];
                    1:       ts = sent_time[ch] + $urandom;
                    default: ts = sent_time[ch] + $urandom_range(1, 50);
                endcase
                case ($urandom_range(19))
                    0:       cnt = sent_count[ch] + 16'h7FFF;
                    1:       cnt = sent_count[ch] + 16'h8000;
                    2:       cnt = sent_count[ch] + 16'h8001;
                    default: cnt = COUNT_W'(sent_count[ch] + $urandom_range(800) - 400);
                endcase
            end
            else
            begin
                cnt = COUNT_W'($urandom);
                ts  = $urandom;
            end
            push_sample(ch, cnt, ts, idle_pct);
        end
        sample_ch.valid <= 1'b0;
    endtask

    task automatic random_config();
        logic [SCALE_W-1:0] cpr;
        if ($urandom_range(3) == 0)
            cpr = SCALE_W'($urandom_range(1, 65535));
        else
            cpr = SCALE_W'($urandom_range(1, 4000));
        configure(cpr, SCALE_W'($urandom_range(65535)), SCALE_W'($urandom_range(65535)));
    endtask

    initial
    begin
        rst_n                   = 1'b0;
        psel                    = 1'b0;
        penable                 = 1'b0;
        pwrite                  = 1'b0;
        paddr                   = '0;
        pwdata                  = '0;
        sample_ch.valid         = 1'b0;
        sample_ch.channel       = 1'b0;
        sample_ch.counter_value = '0;
        sample_ch.time_ms       = '0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            sent_count[i] = '0;
            sent_time[i]  = '0;
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset register values: held zeros, reversal, signed wrap of the count
        push_sample(1'b0, 16'd0, 32'd0, 0);
        push_sample(1'b0, 16'd100, 32'd10, 0);
        push_sample(1'b0, 16'd55, 32'd10, 0);
        push_sample(1'b0, 16'd40, 32'd11, 0);
        push_sample(1'b1, 16'hFFFF, 32'd1, 0);
        push_sample(1'b1, 16'h7FFF, 32'd2, 0);
        push_sample(1'b1, 16'hFFFE, 32'd3, 0);
        push_sample(1'b0, 16'd32807, 32'd12, 0);
        push_sample(1'b0, 16'd32807, 32'hFFFF_FFFF, 0);
        push_sample(1'b0, 16'd32810, 32'd0, 0);
        sample_ch.valid <= 1'b0;

        // zero counts per rev and full scales: largest products either sign
        configure(16'd0, 16'hFFFF, 16'hFFFF);
        push_sample(1'b0, 16'hFFFF, 32'd1, 0);
        push_sample(1'b0, 16'h7FFF, 32'd2, 0);
        push_sample(1'b1, 16'd32765, 32'd4, 0);
        push_sample(1'b1, 16'd32765, 32'd4, 0);
        sample_ch.valid <= 1'b0;

        // one count per rev, zero scales
        configure(16'd1, 16'd0, 16'd0);
        push_sample(1'b0, 16'hFFFF, 32'd3, 0);
        push_sample(1'b1, 16'd1, 32'd5, 0);
        sample_ch.valid <= 1'b0;

        // largest counts per rev, then a write to the unused slot that must not land
        configure(16'hFFFF, 16'd9846, 16'd34542);
        apb_write(REG_UNUSED, 16'd7);
        push_sample(1'b0, 16'hFFFF, 32'd100, 0);
        push_sample(1'b1, 16'hFFFE, 32'd6, 0);
        sample_ch.valid <= 1'b0;

        // random phases under each flow-control pattern
        for (int pass = 0; pass < 2; pass++)
        begin
            for (int mode = 0; mode < 4; mode++)
            begin
                random_config();
                case (mode)
                    0:
                    begin
                        stall_pct = 0;
                        random_samples(RANDOM_ITEMS, 0);
                    end
                    1:
                    begin
                        stall_pct = 0;
                        random_samples(RANDOM_ITEMS, 57);
                    end
                    2:
                    begin
                        stall_pct = 57;
                        random_samples(RANDOM_ITEMS, 0);
                    end
                    default:
                    begin
                        stall_pct = 19;
                        random_samples(RANDOM_ITEMS, 19);
                    end
                endcase
                drain();
            end
        end
        stall_pct = 0;
        drain();

        $display("covered %0d speed words: %0d recomputed, %0d held", sb.checked,
                 sb.updates, sb.holds);
        $display("across %0d register settings and four ready/valid idling patterns",
                 settings_used);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
